// ----- sv/rdsc_pkg.sv -----
// ----------------------------------------------------------------------------
// rdsc_pkg
// Shared types and constants for the radix digit string converter.
// ----------------------------------------------------------------------------
package rdsc_pkg;

  localparam int VALUE_BITS_DEF = 64;
  localparam int MAX_RADIX_DEF  = 16;

  localparam int RADIX_W = 5;
  localparam int DIGIT_W = 4;
  localparam int CHAR_W  = 8;
  localparam int CFG_W   = 64;
  localparam int IDX_W   = 2;

  // bits of the dividend retired per divide cycle
  localparam int DIV_BITS = 8;

  localparam logic [IDX_W-1:0] REG_RADIX      = 2'd0;
  localparam logic [IDX_W-1:0] REG_CHARS_LOW  = 2'd1;
  localparam logic [IDX_W-1:0] REG_CHARS_HIGH = 2'd2;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
  localparam logic [CFG_W-1:0]   CHARS_LOW_RESET  = 64'h3736353433323130;
  localparam logic [CFG_W-1:0]   CHARS_HIGH_RESET = 64'h6665646362613938;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic load;
    logic step;
    logic pop;
  } cmd_t;

  typedef struct packed {
    logic digit_done;
    logic quot_zero;
    logic out_free;
    logic cnt_one;
  } status_t;

endpackage

// ----- sv/rdsc_ctrl.sv -----
// ----------------------------------------------------------------------------
// rdsc_ctrl
// Sequencer: load a value, divide digit by digit, then emit the digit stack.
// ----------------------------------------------------------------------------
module rdsc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  rdsc_pkg::status_t status,
  output rdsc_pkg::cmd_t    cmd
);

  rdsc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rdsc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      rdsc_pkg::ST_IDLE: begin
        if (in_valid) state_next = rdsc_pkg::ST_DIVIDE;
      end
      rdsc_pkg::ST_DIVIDE: begin
        if (status.digit_done && status.quot_zero) state_next = rdsc_pkg::ST_EMIT;
      end
      rdsc_pkg::ST_EMIT: begin
        if (status.out_free && status.cnt_one) state_next = rdsc_pkg::ST_IDLE;
      end
      default: state_next = rdsc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      rdsc_pkg::ST_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.load     = in_valid;
      end
      rdsc_pkg::ST_DIVIDE: begin
        cmd.step = 1'b1;
      end
      rdsc_pkg::ST_EMIT: begin
        cmd.pop = status.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ----- sv/rdsc_datapath.sv -----
// ----------------------------------------------------------------------------
// rdsc_datapath
// Config registers, radix divider (DIV_BITS per cycle), digit stack and
// character output register.
// ----------------------------------------------------------------------------
module rdsc_datapath #(
  parameter int VALUE_BITS = rdsc_pkg::VALUE_BITS_DEF,
  parameter int MAX_RADIX  = rdsc_pkg::MAX_RADIX_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [rdsc_pkg::IDX_W-1:0]    cfg_index,
  input  logic [rdsc_pkg::CFG_W-1:0]    cfg_data,
  input  logic [VALUE_BITS-1:0]         in_value,
  input  rdsc_pkg::cmd_t                cmd,
  output rdsc_pkg::status_t             status,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rdsc_pkg::CHAR_W-1:0]   out_char,
  output logic                          out_last
);

  localparam int STEPS = (VALUE_BITS + rdsc_pkg::DIV_BITS - 1) / rdsc_pkg::DIV_BITS;
  localparam int PAD   = STEPS * rdsc_pkg::DIV_BITS;
  localparam int SW    = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int CW    = $clog2(VALUE_BITS + 1);
  localparam logic [rdsc_pkg::RADIX_W-1:0] RMAX = rdsc_pkg::RADIX_W'(MAX_RADIX);

  logic [rdsc_pkg::RADIX_W-1:0] radix;
  logic [rdsc_pkg::CFG_W-1:0]   chars_low;
  logic [rdsc_pkg::CFG_W-1:0]   chars_high;

  logic [PAD-1:0]               acc, acc_next;
  logic [rdsc_pkg::DIGIT_W-1:0] rem, rem_next;
  logic [SW-1:0]                step_cnt;
  logic [CW-1:0]                cnt;
  logic [rdsc_pkg::DIGIT_W-1:0] stk [VALUE_BITS];
  logic                         digit_done;
  logic [2*rdsc_pkg::CFG_W-1:0] alpha;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix      <= rdsc_pkg::RADIX_RESET;
      chars_low  <= rdsc_pkg::CHARS_LOW_RESET;
      chars_high <= rdsc_pkg::CHARS_HIGH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rdsc_pkg::REG_RADIX: begin
          if (cfg_data < rdsc_pkg::CFG_W'(rdsc_pkg::RADIX_MIN)) radix <= rdsc_pkg::RADIX_MIN;
          else if (cfg_data > rdsc_pkg::CFG_W'(RMAX)) radix <= RMAX;
          else radix <= cfg_data[rdsc_pkg::RADIX_W-1:0];
        end
        rdsc_pkg::REG_CHARS_LOW:  chars_low  <= cfg_data;
        rdsc_pkg::REG_CHARS_HIGH: chars_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // restoring division, DIV_BITS quotient bits per cycle
  always_comb begin
    logic [rdsc_pkg::RADIX_W-1:0] t;
    acc_next = acc;
    rem_next = rem;
    for (int i = 0; i < rdsc_pkg::DIV_BITS; i++) begin
      t        = {rem_next, acc_next[PAD-1]};
      acc_next = {acc_next[PAD-2:0], 1'b0};
      if (t >= radix) begin
        t           = t - radix;
        acc_next[0] = 1'b1;
      end
      rem_next = t[rdsc_pkg::DIGIT_W-1:0];
    end
  end

  assign digit_done = cmd.step && (step_cnt == SW'(STEPS - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc <= PAD'(in_value);
    end else if (cmd.step) begin
      acc <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_cnt <= '0;
      rem      <= '0;
      cnt      <= '0;
    end else if (cmd.load) begin
      step_cnt <= '0;
      rem      <= '0;
      cnt      <= '0;
    end else if (cmd.step) begin
      if (digit_done) begin
        step_cnt <= '0;
        rem      <= '0;
        cnt      <= cnt + CW'(1);
      end else begin
        step_cnt <= step_cnt + SW'(1);
        rem      <= rem_next;
      end
    end else if (cmd.pop) begin
      cnt <= cnt - CW'(1);
    end
  end

  // digit stack: push at the top when a digit completes, pop from the top
  always_ff @(posedge clk) begin
    if (digit_done) begin
      stk[0] <= rem_next;
      for (int i = 1; i < VALUE_BITS; i++) stk[i] <= stk[i-1];
    end else if (cmd.pop) begin
      for (int i = 0; i < VALUE_BITS - 1; i++) stk[i] <= stk[i+1];
    end
  end

  assign alpha = {chars_high, chars_low};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      out_char <= alpha[{stk[0], 3'b000} +: rdsc_pkg::CHAR_W];
      out_last <= (cnt == CW'(1));
    end
  end

  always_comb begin
    status.digit_done = digit_done;
    status.quot_zero  = (acc_next == '0);
    status.out_free   = !out_valid || out_ready;
    status.cnt_one    = (cnt == CW'(1));
  end

endmodule

// ----- sv/radix_digit_string_converter.sv -----
// ----------------------------------------------------------------------------
// radix_digit_string_converter
// Unsigned value to digit string in a configurable radix, MSD first.
// ----------------------------------------------------------------------------
// Slave stream carries one value per request (tdata[63:0] = value; only the
// low VALUE_BITS bits are used). Master stream returns one character per
// request, tlast set on the final character of the string.
// The config port writes radix (index 0, saturated to 2..MAX_RADIX) and the
// two alphabet words (indexes 1 and 2) on any cycle with cfg_we high.
// Each value is divided by the radix once per digit of the result, the
// divider retiring 8 quotient bits per cycle, then the characters are
// emitted MSD first; s_tready is high again once the last character sits in
// the output register. Zero yields the single digit-0 character.
// A stall on the master side holds the output register and pauses emission;
// no character is dropped. Reset (rst, synchronous) returns to idle, clears
// m_tvalid and restores radix 10 and the alphabet "0123456789abcdef".
// ----------------------------------------------------------------------------
module radix_digit_string_converter #(
  parameter int VALUE_BITS = rdsc_pkg::VALUE_BITS_DEF,
  parameter int MAX_RADIX  = rdsc_pkg::MAX_RADIX_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [rdsc_pkg::IDX_W-1:0]  cfg_index,
  input  logic [rdsc_pkg::CFG_W-1:0]  cfg_data,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [63:0]                 s_tdata,   // [63:0] value
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [7:0]                  m_tdata,   // [7:0] digit_char
  output logic                        m_tlast    // last
);

  rdsc_pkg::cmd_t    cmd;
  rdsc_pkg::status_t status;

  rdsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .status   (status),
    .cmd      (cmd)
  );

  rdsc_datapath #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_RADIX  (MAX_RADIX)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_value  (s_tdata[VALUE_BITS-1:0]),
    .cmd       (cmd),
    .status    (status),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_char  (m_tdata),
    .out_last  (m_tlast)
  );

  assign s_tready = cmd.in_ready;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("accepted a request while a conversion is running");

  a_mid_string_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("idle with a string still incomplete");

  a_reset_state: assert property (@(posedge clk)
    rst |=> s_tready && !m_tvalid)
    else $error("reset did not return to idle");

endmodule

// ----- tb/rdsc_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rdsc_checker
// Watches the config port and both streams of the digit string converter,
// predicts the character string of every accepted value from a local copy
// of radix and alphabet, and compares each returned character in order.
// ----------------------------------------------------------------------------
module rdsc_checker #(
  parameter int VALUE_BITS = rdsc_pkg::VALUE_BITS_DEF,
  parameter int MAX_RADIX  = rdsc_pkg::MAX_RADIX_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [rdsc_pkg::IDX_W-1:0]  cfg_index,
  input  logic [rdsc_pkg::CFG_W-1:0]  cfg_data,
  input  logic                        s_tvalid,
  input  logic                        s_tready,
  input  logic [63:0]                 s_tdata,   // [63:0] value
  input  logic                        m_tvalid,
  input  logic                        m_tready,
  input  logic [7:0]                  m_tdata,   // [7:0] digit_char
  input  logic                        m_tlast,
  output int                          fail_count,
  output int                          pending
);
  import rdsc_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } digit_char_t;

  localparam logic [63:0] VALUE_MASK =
    (VALUE_BITS >= 64) ? '1 : ((64'd1 << VALUE_BITS) - 64'd1);

  digit_char_t        want_chars[$];
  logic [RADIX_W-1:0] base_r;
  logic [CFG_W-1:0]   alpha_lo;
  logic [CFG_W-1:0]   alpha_hi;
  int                 errs = 0;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic logic [CHAR_W-1:0] glyph_of(input logic [DIGIT_W-1:0] d);
    if (d < 8)
      return alpha_lo[8*d +: 8];
    return alpha_hi[8*(d-8) +: 8];
  endfunction

  // divide down LSD first, then queue characters MSD first
  function automatic void spell_value(input logic [63:0] v_in);
    logic [63:0]        v;
    logic [63:0]        b;
    logic [DIGIT_W-1:0] digs[64];
    int                 n;
    digit_char_t        c;
    v = v_in & VALUE_MASK;
    b = {{(64-RADIX_W){1'b0}}, base_r};
    n = 0;
    do begin
      digs[n] = DIGIT_W'(v % b);
      v = v / b;
      n++;
    end while (v != 0 && n < 64);
    for (int k = n - 1; k >= 0; k--) begin
      c.ch   = glyph_of(digs[k]);
      c.last = (k == 0);
      want_chars.push_back(c);
    end
  endfunction

  always @(posedge clk) begin
    digit_char_t w;
    if (rst) begin
      want_chars.delete();
      base_r   <= RADIX_RESET;
      alpha_lo <= CHARS_LOW_RESET;
      alpha_hi <= CHARS_HIGH_RESET;
      pending  <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_RADIX: begin
            if (cfg_data < RADIX_MIN)
              base_r <= RADIX_MIN;
            else if (cfg_data > MAX_RADIX)
              base_r <= RADIX_W'(MAX_RADIX);
            else
              base_r <= cfg_data[RADIX_W-1:0];
          end
          REG_CHARS_LOW:  alpha_lo <= cfg_data;
          REG_CHARS_HIGH: alpha_hi <= cfg_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (want_chars.size() == 0) begin
          $error("unexpected character %h (last %b)", m_tdata, m_tlast);
          errs++;
        end else begin
          w = want_chars.pop_front();
          if (m_tdata !== w.ch) begin
            $error("digit_char: expected %h, got %h", w.ch, m_tdata);
            errs++;
          end
          if (m_tlast !== w.last) begin
            $error("last: expected %b, got %b", w.last, m_tlast);
            errs++;
          end
        end
      end
      if (s_tvalid && s_tready)
        spell_value(s_tdata);
      pending <= want_chars.size();
    end
    fail_count <= errs;
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the radix digit string converter: directed corner values and
// radix/alphabet settings, then random values under several idle and stall
// mixes, one long output hold-off; the checker judges every character.
// ----------------------------------------------------------------------------
module tb;
  import rdsc_pkg::*;

  localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 1500;
  localparam int WDOG_LIMIT  = 20000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data = '0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [63:0]       s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [7:0]        m_tdata;
  logic              m_tlast;
  int                fail_count;
  int                pending;

  int   idle_pct = 0;
  int   stall_pct = 0;
  logic hold_go = 1'b0;
  logic hold_taken = 1'b0;
  int   hold_cnt = 0;
  int   wdog = 0;

  always #5 clk = ~clk;

  radix_digit_string_converter dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  rdsc_checker chk (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .fail_count(fail_count), .pending(pending)
  );

  // output side: random stalls, one long hold-off on request
  always @(posedge clk) begin
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      m_tready <= 1'b0;
    end else if (hold_go && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_cnt   <= HOLD_CYCLES;
      m_tready   <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      wdog <= 0;
    else
      wdog <= wdog + 1;
    if (wdog >= WDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_value(input logic [63:0] v);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= {$urandom, $urandom};
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    do @(posedge clk); while (!s_tready);
  endtask

  // pending is a registered copy of the checker queue size, so look only after the next edge
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand_value();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(3))
      0: return r;
      1: return 64'($urandom_range(1000));
      2: return r >> $urandom_range(63);
      default: return (64'd1 << $urandom_range(63)) - 64'($urandom_range(1));
    endcase
  endfunction

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: decimal, standard alphabet
    send_value(64'd0);
    send_value(64'd1);
    send_value(64'd9);
    send_value(64'd10);
    send_value('1);
    send_value(64'h8000_0000_0000_0000);
    settle();

    // radix below range saturates to 2; all-ones gives the longest string
    write_reg(REG_RADIX, 64'd0);
    send_value(64'd0);
    send_value('1);
    send_value(64'h5555_5555_5555_5555);
    settle();

    // radix above range saturates to 16; odd alphabet bytes; unused index
    write_reg(REG_RADIX, 64'd31);
    write_reg(REG_CHARS_LOW, 64'h07ff_8000_7f20_0a1b);
    write_reg(REG_CHARS_HIGH, 64'hc3a5_5a3c_e1d2_0f96);
    write_reg(REG_UNUSED, '1);
    send_value('1);
    send_value(64'h0123_4567_89ab_cdef);
    send_value(64'hfedc_ba98_7654_3210);
    send_value(64'd0);
    settle();

    write_reg(REG_RADIX, 64'd17);
    send_value(64'd255);
    settle();
    write_reg(REG_RADIX, 64'd1);
    send_value(64'd6);
    settle();
    write_reg(REG_RADIX, 64'd3);
    send_value('1);
    send_value(64'd8);
    settle();
    write_reg(REG_CHARS_LOW, CHARS_LOW_RESET);
    write_reg(REG_CHARS_HIGH, CHARS_HIGH_RESET);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 64; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 64; end
        default: begin idle_pct = 24; stall_pct <= 24; end
      endcase
      repeat (4) begin
        settle();
        if ($urandom_range(3) == 0)
          write_reg(REG_RADIX, 64'($urandom_range(31)));
        else
          write_reg(REG_RADIX, 64'($urandom_range(2, 16)));
        if ($urandom_range(2) == 0) begin
          write_reg(REG_CHARS_LOW, {$urandom, $urandom});
          write_reg(REG_CHARS_HIGH, {$urandom, $urandom});
        end
        repeat (6) send_value(rand_value());
      end
      if (ph == 0) begin
        // output held off while requests keep coming
        settle();
        hold_go <= 1'b1;
        repeat (6) send_value(rand_value());
      end
    end

    settle();
    repeat (50) @(posedge clk);
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- radix_digit_string_converter.f -----
sv/rdsc_pkg.sv
sv/rdsc_ctrl.sv
sv/rdsc_datapath.sv
sv/radix_digit_string_converter.sv
tb/rdsc_checker.sv
tb/tb.sv
